FILE: hw/rtl/hdlp_pkg.sv
// hdlp_pkg: shared types and constants of the hashed dictionary block
// request and result structs, slot entry struct, register indexes, fixed widths
// no dependencies
package hdlp_pkg;

  localparam int HASH_W     = 64;
  localparam int CHAR_W     = 8;
  localparam int VAL_W      = 32;
  localparam int CAP_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int HASH_SHIFT = 5;
  localparam int BIT_CNT_W  = 6;

  localparam logic [HASH_W-1:0] SEED_RESET = 64'd5381;
  localparam logic [CAP_W-1:0]  CAP_RESET  = 9'd256;
  // largest capacity the 9-bit register can name
  localparam int CAP_MAX = 511;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HASH_SEED = 1'b0,
    CFG_CAPACITY  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_PROBE,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic              func;
    logic [CHAR_W-1:0] key_char;
    logic              key_last;
    logic [VAL_W-1:0]  value;
  } in_req_t;

  typedef struct packed {
    logic             success;
    logic [VAL_W-1:0] value_out;
  } out_res_t;

  typedef struct packed {
    logic [HASH_W-1:0] key;
    logic [VAL_W-1:0]  value;
  } slot_entry_t;

endpackage

FILE: hw/rtl/hashed_dictionary_linear_probe.sv
// hashed_dictionary_linear_probe: djb2 string hash with an open addressing table
// top level: command port, config port, sequencer, modulo unit, probe logic
// depends on hdlp_pkg and hdlp_slot_mem
//
// Usage: a key is sent as one request per character on in_data, taken when
// start is high and busy is low. Each character folds into a 64-bit running
// hash (hash*33 + char) and yields no result; the next character can follow
// in the next cycle. The character with key_last set also carries func
// (insert or lookup) and value. For it the block goes busy, computes the home
// slot as hash mod capacity with a restoring remainder unit that takes one
// hash bit per cycle, then probes linearly: an insert checks each probed
// slot, a lookup reads the slot memory (registered) then compares. The result
// shows on out_data for one cycle with out_strobe, in the cycle after the
// final probe; a full-table insert answers in the cycle after the request.
// The receiver cannot stall. The user must write registers on the cfg channel
// (cfg_ready is always high) only while no key is in flight; the block
// does not enforce it. Reset empties the table, zeroes the entry count, loads
// seed 5381 and capacity 256; no clearing pass is needed.
module hashed_dictionary_linear_probe #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  hdlp_pkg::in_req_t               in_data,
  output logic                            out_strobe,
  output hdlp_pkg::out_res_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hdlp_pkg::HASH_W-1:0]     cfg_data
);
  import hdlp_pkg::*;

  // slots beyond the largest nameable capacity are never touched
  localparam int SLOT_CNT = (TABLE_DEPTH < CAP_MAX) ? TABLE_DEPTH : CAP_MAX;
  localparam int IDX_W    = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;
  localparam logic [CAP_W-1:0] SLOT_CNT_C = CAP_W'(SLOT_CNT);

  state_t state_r, state_nxt;

  logic [HASH_W-1:0]    seed_r, seed_nxt;
  logic [CAP_W-1:0]     cap_r, cap_nxt;
  logic [HASH_W-1:0]    acc_r, acc_nxt;
  logic                 key_active_r, key_active_nxt;
  logic [HASH_W-1:0]    hash_r, hash_nxt;
  logic                 func_r, func_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [CAP_W-1:0]     cap_eff_r, cap_eff_nxt;
  logic [CAP_W-1:0]     rem_r, rem_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CAP_W-1:0]     off_r, off_nxt;
  logic [SLOT_CNT-1:0]  valid_r, valid_nxt;
  logic [CAP_W-1:0]     count_r, count_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  out_res_t             out_data_r, out_data_nxt;

  logic                 in_acc;
  logic [HASH_W-1:0]    hash_base;
  logic [HASH_W-1:0]    hash_step;
  logic [CAP_W-1:0]     cap_eff;
  logic                 table_full;
  logic [CAP_W:0]       rem_sh;
  logic [CAP_W-1:0]     rem_step;
  logic [CAP_W-1:0]     idx_inc;
  logic [IDX_W-1:0]     idx_adv;
  logic                 last_probe;
  logic                 slot_used;
  logic                 key_match;

  logic                 mem_wr_en;
  logic                 mem_rd_en;
  slot_entry_t          mem_wr_entry;
  slot_entry_t          mem_rd_entry;

  assign in_acc    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign hash_base = key_active_r ? acc_r : seed_r;
  assign hash_step = (hash_base << HASH_SHIFT) + hash_base + HASH_W'(in_data.key_char);

  always_comb begin
    cap_eff = cap_r;
    if (cap_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_r > SLOT_CNT_C) begin
      cap_eff = SLOT_CNT_C;
    end
  end

  assign table_full = (count_r >= cap_eff);

  // one restoring remainder step per cycle, msb of the hash first
  assign rem_sh   = {rem_r, hash_r[bit_cnt_r]};
  assign rem_step = (rem_sh >= {1'b0, cap_eff_r}) ? CAP_W'(rem_sh - {1'b0, cap_eff_r})
                                                   : rem_sh[CAP_W-1:0];

  assign idx_inc    = CAP_W'(idx_r) + CAP_W'(1);
  assign idx_adv    = (idx_inc == cap_eff_r) ? '0 : idx_inc[IDX_W-1:0];
  assign last_probe = ((off_r + CAP_W'(1)) == cap_eff_r);
  assign slot_used  = valid_r[idx_r];
  assign key_match  = (mem_rd_entry.key == hash_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.key_last) begin
          if (in_data.func == FUNC_INSERT && table_full) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (bit_cnt_r == '0) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        priority if (!slot_used) begin
          state_nxt = ST_IDLE;
        end else if (func_r == FUNC_LOOKUP) begin
          state_nxt = ST_CHECK;
        end else if (last_probe) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      ST_CHECK: begin
        if (key_match || last_probe) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    seed_nxt       = seed_r;
    cap_nxt        = cap_r;
    acc_nxt        = acc_r;
    key_active_nxt = key_active_r;
    hash_nxt       = hash_r;
    func_nxt       = func_r;
    val_nxt        = val_r;
    cap_eff_nxt    = cap_eff_r;
    rem_nxt        = rem_r;
    bit_cnt_nxt    = bit_cnt_r;
    idx_nxt        = idx_r;
    off_nxt        = off_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    mem_wr_en      = 1'b0;
    mem_rd_en      = 1'b0;
    mem_wr_entry   = '{key: hash_r, value: val_r};

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HASH_SEED: seed_nxt = cfg_data;
        CFG_CAPACITY:  cap_nxt  = cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_data.key_last) begin
            acc_nxt        = hash_step;
            key_active_nxt = 1'b1;
          end else begin
            key_active_nxt = 1'b0;
            hash_nxt       = hash_step;
            func_nxt       = in_data.func;
            val_nxt        = in_data.value;
            cap_eff_nxt    = cap_eff;
            rem_nxt        = '0;
            bit_cnt_nxt    = '1;
            off_nxt        = '0;
            if (in_data.func == FUNC_INSERT && table_full) begin
              out_strobe_nxt = 1'b1;
              out_data_nxt   = '{success: 1'b0, value_out: '0};
            end
          end
        end
      end
      ST_MOD: begin
        rem_nxt     = rem_step;
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        // remainder is below capacity, so it fits the slot index
        idx_nxt     = rem_step[IDX_W-1:0];
      end
      ST_PROBE: begin
        mem_rd_en = (func_r == FUNC_LOOKUP);
        priority if (!slot_used) begin
          out_strobe_nxt = 1'b1;
          if (func_r == FUNC_INSERT) begin
            mem_wr_en        = 1'b1;
            valid_nxt[idx_r] = 1'b1;
            count_nxt        = count_r + CAP_W'(1);
            out_data_nxt     = '{success: 1'b1, value_out: '0};
          end else begin
            out_data_nxt     = '{success: 1'b0, value_out: '0};
          end
        end else if (func_r == FUNC_INSERT) begin
          if (last_probe) begin
            out_strobe_nxt = 1'b1;
            out_data_nxt   = '{success: 1'b0, value_out: '0};
          end else begin
            idx_nxt = idx_adv;
            off_nxt = off_r + CAP_W'(1);
          end
        end
      end
      ST_CHECK: begin
        priority if (key_match) begin
          out_strobe_nxt = 1'b1;
          out_data_nxt   = '{success: 1'b1, value_out: mem_rd_entry.value};
        end else if (last_probe) begin
          out_strobe_nxt = 1'b1;
          out_data_nxt   = '{success: 1'b0, value_out: '0};
        end else begin
          idx_nxt = idx_adv;
          off_nxt = off_r + CAP_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seed_r       <= SEED_RESET;
      cap_r        <= CAP_RESET;
      key_active_r <= 1'b0;
      valid_r      <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seed_r       <= seed_nxt;
      cap_r        <= cap_nxt;
      key_active_r <= key_active_nxt;
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    hash_r     <= hash_nxt;
    func_r     <= func_nxt;
    val_r      <= val_nxt;
    cap_eff_r  <= cap_eff_nxt;
    rem_r      <= rem_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    idx_r      <= idx_nxt;
    off_r      <= off_nxt;
    out_data_r <= out_data_nxt;
  end

  hdlp_slot_mem #(
    .DEPTH  (SLOT_CNT),
    .ADDR_W (IDX_W)
  ) u_slot_mem (
    .clk      (clk),
    .wr_en    (mem_wr_en),
    .rd_en    (mem_rd_en),
    .addr     (idx_r),
    .wr_entry (mem_wr_entry),
    .rd_entry (mem_rd_entry)
  );

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

FILE: hw/rtl/hdlp_slot_mem.sv
// hdlp_slot_mem: slot storage for stored hashes and handles
// single address port, one write or one registered read per cycle
// depends on hdlp_pkg
module hdlp_slot_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   addr,
  input  hdlp_pkg::slot_entry_t wr_entry,
  output hdlp_pkg::slot_entry_t rd_entry
);
  import hdlp_pkg::*;

  slot_entry_t mem [DEPTH];
  slot_entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem[addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

FILE: tb/tb_hashed_dictionary_linear_probe.sv
// tb: self-checking bench for the hashed dictionary with linear probing
// directed plan plus random key streams, checked against an in-bench table predictor
// depends on hdlp_pkg and the hashed_dictionary_linear_probe rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hdlp_pkg::*;

  localparam int DEPTH           = 256;
  localparam int CLK_HALF        = 2;
  localparam int RST_CYCLES      = 10;
  // modulo pass plus a lookup over every slot, with margin
  localparam int MAX_LAT         = 64 + 2 * DEPTH + 8;
  localparam int CFG_SETTLE      = 4;
  localparam int STALL_LIMIT     = 8 * MAX_LAT;
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int POOL            = 64;
  localparam int MAXLEN          = 12;

  typedef struct packed {
    logic              is_cfg;
    cfg_reg_t          sel;
    logic [HASH_W-1:0] data;
    in_req_t           req;
    logic              typed;
    out_res_t          want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_req_t            in_data;
  logic               out_strobe;
  out_res_t           out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [HASH_W-1:0]  cfg_data;

  hashed_dictionary_linear_probe #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // predicted dictionary state
  logic [HASH_W-1:0] seed_r;
  logic [CAP_W-1:0]  cap_r;
  logic [HASH_W-1:0] run_hash;
  logic [HASH_W-1:0] slot_key [DEPTH];
  logic [VAL_W-1:0]  slot_val [DEPTH];
  bit                slot_used [DEPTH];
  int unsigned       n_stored;
  bit                in_key;

  out_res_t  expected_q [$];
  plan_row_t plan [$];
  out_res_t  want_r;
  out_res_t  got_r;

  logic [7:0] pool_chars [POOL][MAXLEN];
  int         pool_len [POOL];
  int         pool_n;

  bit gaps_on;
  int n_items, n_keys, n_inserts, n_lookups, n_hits, n_results, n_writes, n_errors;
  int stall_cycles;

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    n_errors++;
  endtask

  function automatic in_req_t rand_req();
    in_req_t r;
    r.func     = 1'($urandom_range(0, 1));
    r.key_char = 8'($urandom_range(0, 255));
    r.key_last = 1'($urandom_range(0, 1));
    r.value    = $urandom;
    return r;
  endfunction

  task automatic dict_predict(input in_req_t r, output bit produced, output out_res_t res);
    logic [HASH_W-1:0] h;
    int unsigned cap, slot;
    bit done;
    produced = 1'b0;
    res = '0;
    if (!in_key) run_hash = seed_r;
    run_hash = (run_hash << HASH_SHIFT) + run_hash + 64'(r.key_char);
    if (!r.key_last) begin
      in_key = 1'b1;
    end else begin
      h = run_hash;
      in_key = 1'b0;
      run_hash = seed_r;
      // out-of-range capacity clamps to 1..DEPTH
      cap = (cap_r == 0) ? 1 : ((cap_r > DEPTH) ? DEPTH : cap_r);
      slot = int'(h % 64'(cap));
      done = 1'b0;
      produced = 1'b1;
      n_keys++;
      if (r.func == FUNC_INSERT) begin
        n_inserts++;
        if (n_stored < cap) begin
          for (int k = 0; k < cap && !done; k++) begin
            if (!slot_used[slot]) begin
              slot_used[slot] = 1'b1;
              slot_key[slot] = h;
              slot_val[slot] = r.value;
              n_stored++;
              res.success = 1'b1;
              done = 1'b1;
            end else begin
              slot = (slot + 1 == cap) ? 0 : slot + 1;
            end
          end
        end
      end else begin
        n_lookups++;
        for (int k = 0; k < cap && !done; k++) begin
          if (!slot_used[slot]) begin
            done = 1'b1;
          end else if (slot_key[slot] == h) begin
            res.success = 1'b1;
            res.value_out = slot_val[slot];
            n_hits++;
            done = 1'b1;
          end else begin
            slot = (slot + 1 == cap) ? 0 : slot + 1;
          end
        end
      end
    end
  endtask

  task automatic send_char(input in_req_t r, input bit typed, input out_res_t want);
    bit produced;
    out_res_t res;
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 25) begin
        start <= 1'b0;
        in_data <= rand_req();
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy);
    n_items++;
    dict_predict(r, produced, res);
    if (produced) expected_q.push_back(typed ? want : res);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [HASH_W-1:0] d);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_writes++;
    if (sel == CFG_HASH_SEED) begin
      seed_r = d;
      if (!in_key) run_hash = d;
    end else begin
      cap_r = d[CAP_W-1:0];
    end
  endtask

  task automatic plan_item(input logic f, input logic [7:0] ch, input logic last,
                           input logic [VAL_W-1:0] v, input logic typed,
                           input logic s, input logic [VAL_W-1:0] vo);
    plan_row_t row;
    row = '0;
    row.req.func = f;
    row.req.key_char = ch;
    row.req.key_last = last;
    row.req.value = v;
    row.typed = typed;
    row.want.success = s;
    row.want.value_out = vo;
    plan.push_back(row);
  endtask

  task automatic plan_cfg(input cfg_reg_t sel, input logic [HASH_W-1:0] d);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.sel = sel;
    row.data = d;
    plan.push_back(row);
  endtask

  task automatic send_key();
    logic [7:0] kbuf [MAXLEN];
    int len, pick, mode;
    logic f;
    logic [VAL_W-1:0] v;
    in_req_t r;
    mode = $urandom_range(0, 99);
    if (pool_n == 0 || mode < 45 || mode >= 85) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAXLEN) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) kbuf[i] = 8'($urandom_range(0, 255));
      f = (mode >= 85) ? FUNC_LOOKUP : FUNC_INSERT;
      if (f == FUNC_INSERT) begin
        if (pool_n < POOL) begin
          pick = pool_n;
          pool_n = pool_n + 1;
        end else begin
          pick = $urandom_range(0, POOL - 1);
        end
        pool_len[pick] = len;
        for (int i = 0; i < len; i++) pool_chars[pick][i] = kbuf[i];
      end
    end else begin
      // known key: mostly a lookup, sometimes a duplicate insert
      pick = $urandom_range(0, pool_n - 1);
      len = pool_len[pick];
      for (int i = 0; i < len; i++) kbuf[i] = pool_chars[pick][i];
      f = (mode < 75) ? FUNC_LOOKUP : FUNC_INSERT;
    end
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    for (int i = 0; i < len; i++) begin
      r = rand_req();
      r.key_char = kbuf[i];
      r.key_last = (i == len - 1);
      if (r.key_last) begin
        r.func = f;
        r.value = v;
      end
      send_char(r, 1'b0, '0);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      got_r = out_data;
      n_results++;
      if (expected_q.size() == 0) begin
        note_mismatch("result strobe with no request waiting");
      end else begin
        want_r = expected_q.pop_front();
        if (got_r.success !== want_r.success)
          note_mismatch($sformatf("result %0d success got %0b want %0b",
                                  n_results, got_r.success, want_r.success));
        if (got_r.value_out !== want_r.value_out)
          note_mismatch($sformatf("result %0d value_out got %h want %h",
                                  n_results, got_r.value_out, want_r.value_out));
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without progress", stall_cycles);
      $display("hashed_dictionary_linear_probe verification failed");
      $finish;
    end
  end

  initial begin
    logic [HASH_W-1:0] seed;
    logic [CAP_W-1:0] cap;
    int target;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stall_cycles = 0;
    seed_r = SEED_RESET;
    cap_r = CAP_RESET;
    run_hash = SEED_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_val[i] = '0;
    end
    n_stored = 0;
    in_key = 1'b0;
    pool_n = 0;
    gaps_on = 1'b1;

    // empty table after reset: a lookup misses
    plan_item(FUNC_LOOKUP, 8'h41, 1'b1, 32'h0, 1'b1, 1'b0, 32'h0);
    // two-character key, func and value only count on the last character
    plan_item(FUNC_LOOKUP, 8'h41, 1'b0, 32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_INSERT, 8'h42, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0);
    plan_item(FUNC_INSERT, 8'h41, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_LOOKUP, 8'h42, 1'b1, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // zero and all-ones characters, zero handle
    plan_item(FUNC_LOOKUP, 8'h00, 1'b0, 32'h1, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_INSERT, 8'hFF, 1'b1, 32'h0, 1'b1, 1'b1, 32'h0);
    plan_item(FUNC_INSERT, 8'h00, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_LOOKUP, 8'hFF, 1'b1, 32'h5555_5555, 1'b1, 1'b1, 32'h0);
    plan_item(FUNC_LOOKUP, 8'hFF, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_LOOKUP, 8'h00, 1'b1, 32'h0, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_INSERT, 8'h80, 1'b1, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_INSERT, 8'h01, 1'b1, 32'h1234_5678, 1'b0, 1'b0, 32'h0);
    // zero seed, capacity 0 runs as 1 and the table counts as full
    plan_cfg(CFG_HASH_SEED, 64'h0);
    plan_cfg(CFG_CAPACITY, 64'h0);
    plan_item(FUNC_INSERT, 8'h43, 1'b1, 32'h1, 1'b1, 1'b0, 32'h0);
    plan_item(FUNC_LOOKUP, 8'h00, 1'b1, 32'h0, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_LOOKUP, 8'h41, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_LOOKUP, 8'h42, 1'b1, 32'h0, 1'b0, 1'b0, 32'h0);
    // all-ones seed wraps the hash, capacity above the table clamps
    plan_cfg(CFG_HASH_SEED, '1);
    plan_cfg(CFG_CAPACITY, 64'd511);
    plan_item(FUNC_INSERT, 8'hFF, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_INSERT, 8'hFF, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_INSERT, 8'hFF, 1'b1, 32'h0F0F_0F0F, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_LOOKUP, 8'hFF, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_LOOKUP, 8'hFF, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0);
    plan_item(FUNC_LOOKUP, 8'hFF, 1'b1, 32'h0, 1'b0, 1'b0, 32'h0);

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].sel, plan[i].data);
      else send_char(plan[i].req, plan[i].typed, plan[i].want);
    end

    // random phases; entries persist, so a small capacity comes first
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin seed = SEED_RESET; cap = 9'd12; end
        1: begin seed = {$urandom, $urandom}; cap = 9'd256; end
        2: begin seed = '1; cap = 9'($urandom_range(17, 255)); end
        3: begin seed = '0; cap = 9'd511; end
        default: begin seed = {$urandom, $urandom}; cap = 9'($urandom_range(1, 300)); end
      endcase
      // one phase runs back to back with no gaps
      gaps_on = (ph != 2);
      write_reg(CFG_HASH_SEED, seed);
      write_reg(CFG_CAPACITY, 64'(cap));
      target = n_items + ITEMS_PER_PHASE;
      while (n_items < target) send_key();
    end

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (MAX_LAT) @(posedge clk);

    $display("covered %0d requests in %0d keys: %0d inserts, %0d lookups (%0d hits)",
             n_items, n_keys, n_inserts, n_lookups, n_hits);
    $display("%0d results checked over %0d register writes, %0d entries stored",
             n_results, n_writes, n_stored);
    if (n_errors == 0)
      $display("hashed_dictionary_linear_probe verification clean");
    else
      $display("hashed_dictionary_linear_probe verification failed");
    $finish;
  end

endmodule
